### rtl/mcbf_pkg.sv
// Shared types, constants and helpers of the bisection coefficient filter.
// Used by mcbf_arith and mem_coefficient_bisection_filter_unit; no dependencies.
`default_nettype none

package mcbf_pkg;

    localparam int TABLE_DEPTH_DEF    = 1024;
    localparam int STEP_FRAC_BITS_DEF = 7;
    localparam int TABLE_MAX_DEF      = 8;

    localparam logic [6:0]  ITER_LIMIT_RST = 7'd64;
    localparam logic [16:0] CONV_THR_RST   = 17'd7;

    localparam logic REG_ITER_LIMIT = 1'b0;
    localparam logic REG_CONV_THR   = 1'b1;

    localparam logic [63:0] ONE30  = 64'd1 << 30;
    localparam logic [63:0] C1_Q30 = 64'd856722024;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } t_arith_op;

    typedef struct packed {
        logic      start;
        t_arith_op op;
    } t_arith_cmd;

    function automatic logic [63:0] f_mag(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [63:0] f_rmul30(input logic [63:0] a, input logic [63:0] b);
        return (a * b + (ONE30 >> 1)) >> 30;
    endfunction

endpackage

`default_nettype wire

### rtl/mem_coefficient_bisection_filter_unit.sv
// Alpha zero or negative goes straight to the output register. Otherwise a setup
// (a divide in mode 0, a multiply in mode 1), then bisection steps on the shared
// arithmetic unit: one multiply per step in mode 0, two multiplies and three divides
// on the one-bit-per-cycle divider in mode 1; mode 0 adds a final scaling multiply.
// One item at a time; the next is taken once the result sits in the output
// register. Synchronous active-low reset clears control and resets the two registers.
`default_nettype none

module mem_coefficient_bisection_filter_unit #(
    parameter int TABLE_DEPTH    = mcbf_pkg::TABLE_DEPTH_DEF,
    parameter int STEP_FRAC_BITS = mcbf_pkg::STEP_FRAC_BITS_DEF,
    parameter int TABLE_MAX      = mcbf_pkg::TABLE_MAX_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_mode,
    input  logic signed [31:0] i_data_value,
    input  logic signed [31:0] i_alpha,
    input  logic [30:0]        i_signal_sigma,
    input  logic [30:0]        i_noise_sigma,
    input  logic signed [31:0] i_model_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_restored_value,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import mcbf_pkg::*;

    localparam int IDXW = $clog2(TABLE_DEPTH);
    localparam logic signed [63:0] TOP_ARG = 64'(TABLE_MAX) << 16;
    localparam logic signed [63:0] IDX_RND = 64'd1 << (15 - STEP_FRAC_BITS);
    localparam logic signed [63:0] THREE_Q = 64'd3 << 16;
    localparam logic signed [63:0] RES_MAX = 64'sd2147483647;
    localparam logic signed [63:0] RES_MIN = -64'sd2147483648;

    typedef logic [31:0] t_rom [TABLE_DEPTH];

    typedef enum logic [1:0] {
        G_ZERO,
        G_IDX,
        G_TOP
    } t_gcls;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PRE,
        S_PREDIV,
        S_PREMUL,
        S_MID,
        S_ARG,
        S_DIVS,
        S_DIVN,
        S_ROM,
        S_GRAD,
        S_MULA,
        S_MULAW,
        S_MULB,
        S_MULBW,
        S_UPD,
        S_WID,
        S_WDIV,
        S_FIN,
        S_FINW,
        S_RES
    } t_state;

    function automatic t_rom f_build(input logic sel_hn);
        t_rom        rom;
        logic [63:0] e, q, term, q2, g, a, fsum, f0, f, t, corr, ev, cg, xq, xe, xc;
        e    = 64'd1 << (29 - 2 * STEP_FRAC_BITS);
        q    = ONE30;
        term = ONE30;
        g    = ONE30;
        fsum = '0;
        f0   = '0;
        for (int k = 1; k <= 6; k++) begin
            term = f_rmul30(term, e) / 64'(k);
            if (k % 2 == 1) begin
                q = q - term;
            end else begin
                q = q + term;
            end
        end
        q2 = f_rmul30(q, q);
        a  = q;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (i > 0) begin
                g = f_rmul30(g, a);
                a = f_rmul30(a, q2);
            end
            f    = f_rmul30(C1_Q30, g);
            fsum = fsum + f;
            if (i == 0) begin
                f0 = f;
            end
            t = (2 * fsum - f0 - f + (64'd1 << STEP_FRAC_BITS)) >> (STEP_FRAC_BITS + 1);
            if (i == 0) begin
                t = '0;
            end
            corr = (f * 64'(i) / 64'd12 + (64'd1 << (3 * STEP_FRAC_BITS - 1)))
                   >> (3 * STEP_FRAC_BITS);
            ev = t + corr;
            if (ev > ONE30) begin
                ev = ONE30;
            end
            cg = (f < C1_Q30) ? ((C1_Q30 - f + (64'd1 << 13)) >> 14) : 64'd0;
            xq = 64'(i) << (16 - STEP_FRAC_BITS);
            xe = (xq * ev + (64'd1 << 29)) >> 30;
            xc = (xq * (ONE30 - ev) + (64'd1 << 29)) >> 30;
            rom[i] = sel_hn ? 32'(cg + xc) : 32'(cg - xe);
        end
        return rom;
    endfunction

    localparam t_rom HS_ROM = f_build(1'b0);
    localparam t_rom HN_ROM = f_build(1'b1);
    localparam logic signed [63:0] HS_LAST = 64'($signed(HS_ROM[TABLE_DEPTH - 1]));
    localparam logic signed [63:0] HN_LAST = 64'($signed(HN_ROM[TABLE_DEPTH - 1]));

    function automatic t_gcls f_cls(input logic signed [63:0] v);
        if (v >= TOP_ARG) begin
            return G_TOP;
        end else if (v > 0) begin
            return G_IDX;
        end
        return G_ZERO;
    endfunction

    function automatic logic [IDXW-1:0] f_index(input logic signed [63:0] v);
        logic [63:0] idx;
        idx = 64'(v + IDX_RND) >> (16 - STEP_FRAC_BITS);
        if (idx > 64'(TABLE_DEPTH - 1)) begin
            idx = 64'(TABLE_DEPTH - 1);
        end
        return idx[IDXW-1:0];
    endfunction

    t_state              r_state;
    logic [6:0]          r_iter_limit;
    logic [16:0]         r_conv_thr;
    logic                r_mode;
    logic signed [31:0]  r_d;
    logic signed [31:0]  r_alpha;
    logic signed [31:0]  r_m;
    logic [30:0]         r_sig;
    logic [30:0]         r_sign;
    logic [6:0]          r_lim;
    logic [6:0]          r_iter;
    logic                r_ge;
    logic signed [63:0]  r_valdat;
    logic signed [63:0]  r_lo;
    logic signed [63:0]  r_hi;
    logic signed [63:0]  r_c;
    logic signed [63:0]  r_args;
    logic signed [63:0]  r_argn;
    logic signed [63:0]  r_gs;
    logic signed [63:0]  r_gn;
    logic signed [63:0]  r_asn;
    logic signed [63:0]  r_p1;
    logic signed [64:0]  r_diff;
    t_gcls               r_cls_s;
    t_gcls               r_cls_n;
    logic [31:0]         r_hs_q;
    logic [31:0]         r_hn_q;
    t_arith_cmd          r_cmd;
    logic signed [63:0]  r_opa;
    logic signed [63:0]  r_opb;
    logic                r_out_valid;
    logic signed [31:0]  r_out;

    logic                ar_done;
    logic signed [63:0]  ar_result;
    logic                in_take;
    logic                cfg_wr;
    logic [32:0]         dm;
    logic [30:0]         sig_max;
    logic signed [63:0]  c_next;
    logic signed [63:0]  width;
    logic signed [63:0]  thr;
    logic                more;
    logic signed [63:0]  res_signed;
    logic signed [31:0]  res_sat;
    logic signed [63:0]  w_sel;

    mcbf_arith u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (r_cmd),
        .i_opa    (r_opa),
        .i_opb    (r_opb),
        .o_done   (ar_done),
        .o_result (ar_result)
    );

    always_comb begin
        in_take = i_valid && (r_state == S_IDLE);
        cfg_wr  = psel && penable && pwrite;
        dm = r_ge ? 33'($signed({r_d[31], r_d}) - $signed({r_m[31], r_m}))
                  : 33'($signed({r_m[31], r_m}) - $signed({r_d[31], r_d}));
        sig_max = (r_sig > r_sign) ? r_sig : r_sign;
        c_next  = (r_lo + r_hi) >>> 1;
        width   = r_hi - r_lo;
        thr     = 64'(r_conv_thr);
        w_sel   = r_mode ? ar_result : width;
        more    = (w_sel > thr) && (r_iter < r_lim);
        res_signed = (r_ge ? r_c : -r_c) + 64'(r_m);
        if (res_signed > RES_MAX) begin
            res_sat = RES_MAX[31:0];
        end else if (res_signed < RES_MIN) begin
            res_sat = RES_MIN[31:0];
        end else begin
            res_sat = res_signed[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_hs_q <= HS_ROM[f_index(r_args)];
        r_hn_q <= HN_ROM[f_index(r_argn)];
    end

    always_ff @(posedge i_clk) begin
        r_cmd.start <= 1'b0;
        if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (cfg_wr) begin
            unique case (paddr[2])
                REG_ITER_LIMIT: r_iter_limit <= pwdata[6:0];
                REG_CONV_THR:   r_conv_thr   <= pwdata[16:0];
                default:        r_conv_thr   <= r_conv_thr;
            endcase
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    r_mode  <= i_mode;
                    r_d     <= i_data_value;
                    r_alpha <= i_alpha;
                    r_m     <= i_model_value;
                    r_sig   <= (i_signal_sigma == '0) ? 31'd1 : i_signal_sigma;
                    r_sign  <= (i_noise_sigma == '0) ? 31'd1 : i_noise_sigma;
                    r_lim   <= (r_iter_limit == '0) ? 7'd1 : r_iter_limit;
                    r_ge    <= i_data_value >= i_model_value;
                    r_state <= S_PRE;
                end
            end
            S_PRE: begin
                r_lo   <= '0;
                r_iter <= '0;
                r_c    <= '0;
                if (r_alpha == '0) begin
                    r_c     <= 64'(r_d);
                    r_ge    <= 1'b1;
                    r_m     <= '0;
                    r_state <= S_RES;
                end else if (r_alpha < 0) begin
                    r_state <= S_RES;
                end else if (!r_mode) begin
                    r_cmd   <= '{start: 1'b1, op: OP_DIV};
                    r_opa   <= 64'(dm);
                    r_opb   <= 64'(r_sig);
                    r_state <= S_PREDIV;
                end else begin
                    r_valdat <= 64'(dm);
                    r_hi     <= 64'(dm) + 64'(sig_max) * 64'd3;
                    r_cmd    <= '{start: 1'b1, op: OP_MUL};
                    r_opa    <= 64'(r_alpha);
                    r_opb    <= 64'(r_sign);
                    r_state  <= S_PREMUL;
                end
            end
            S_PREDIV: begin
                if (ar_done) begin
                    r_valdat <= ar_result;
                    r_hi     <= ar_result + THREE_Q;
                    r_state  <= S_MID;
                end
            end
            S_PREMUL: begin
                if (ar_done) begin
                    r_asn   <= ar_result;
                    r_state <= S_MID;
                end
            end
            S_MID: begin
                r_iter  <= r_iter + 7'd1;
                r_c     <= c_next;
                r_state <= S_ARG;
            end
            S_ARG: begin
                if (!r_mode) begin
                    r_args  <= r_valdat - r_c;
                    r_argn  <= r_c;
                    r_state <= S_ROM;
                end else begin
                    r_cmd   <= '{start: 1'b1, op: OP_DIV};
                    r_opa   <= r_valdat - r_c;
                    r_opb   <= 64'(r_sig);
                    r_state <= S_DIVS;
                end
            end
            S_DIVS: begin
                if (ar_done) begin
                    r_args  <= ar_result;
                    r_cmd   <= '{start: 1'b1, op: OP_DIV};
                    r_opa   <= r_c;
                    r_opb   <= 64'(r_sign);
                    r_state <= S_DIVN;
                end
            end
            S_DIVN: begin
                if (ar_done) begin
                    r_argn  <= ar_result;
                    r_state <= S_ROM;
                end
            end
            S_ROM: begin
                r_cls_s <= f_cls(r_args);
                r_cls_n <= f_cls(r_argn);
                r_state <= S_GRAD;
            end
            S_GRAD: begin
                unique case (r_cls_s)
                    G_TOP:   r_gs <= HS_LAST - r_args;
                    G_IDX:   r_gs <= 64'($signed(r_hs_q));
                    default: r_gs <= '0;
                endcase
                unique case (r_cls_n)
                    G_TOP:   r_gn <= HN_LAST;
                    G_IDX:   r_gn <= 64'($signed(r_hn_q));
                    default: r_gn <= '0;
                endcase
                r_state <= S_MULA;
            end
            S_MULA: begin
                r_cmd <= '{start: 1'b1, op: OP_MUL};
                if (!r_mode) begin
                    r_opa <= 64'(r_alpha);
                    r_opb <= r_gn;
                end else begin
                    r_opa <= 64'(r_sig);
                    r_opb <= r_gs;
                end
                r_state <= S_MULAW;
            end
            S_MULAW: begin
                if (ar_done) begin
                    if (!r_mode) begin
                        r_diff  <= 65'(r_gs) + 65'(ar_result);
                        r_state <= S_UPD;
                    end else begin
                        r_p1    <= ar_result;
                        r_state <= S_MULB;
                    end
                end
            end
            S_MULB: begin
                r_cmd   <= '{start: 1'b1, op: OP_MUL};
                r_opa   <= r_asn;
                r_opb   <= r_gn;
                r_state <= S_MULBW;
            end
            S_MULBW: begin
                if (ar_done) begin
                    r_diff  <= 65'(r_p1) + 65'(ar_result);
                    r_state <= S_UPD;
                end
            end
            S_UPD: begin
                if (r_diff > 0) begin
                    r_hi <= r_c;
                end else begin
                    r_lo <= r_c;
                end
                r_state <= S_WID;
            end
            S_WID: begin
                if (!r_mode) begin
                    r_state <= more ? S_MID : S_FIN;
                end else begin
                    r_cmd   <= '{start: 1'b1, op: OP_DIV};
                    r_opa   <= width;
                    r_opb   <= 64'(r_sig);
                    r_state <= S_WDIV;
                end
            end
            S_WDIV: begin
                if (ar_done) begin
                    r_state <= more ? S_MID : S_FIN;
                end
            end
            S_FIN: begin
                if (!r_mode) begin
                    r_cmd   <= '{start: 1'b1, op: OP_MUL};
                    r_opa   <= r_c;
                    r_opb   <= 64'(r_sig);
                    r_state <= S_FINW;
                end else begin
                    r_state <= S_RES;
                end
            end
            S_FINW: begin
                if (ar_done) begin
                    r_c     <= ar_result;
                    r_state <= S_RES;
                end
            end
            S_RES: begin
                if (!r_out_valid || !i_stall) begin
                    r_out       <= res_sat;
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
            end
            default: r_state <= S_IDLE;
        endcase
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_cmd.start  <= 1'b0;
            r_iter_limit <= ITER_LIMIT_RST;
            r_conv_thr   <= CONV_THR_RST;
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_ITER_LIMIT: prdata = {25'd0, r_iter_limit};
            REG_CONV_THR:   prdata = {15'd0, r_conv_thr};
            default:        prdata = '0;
        endcase
    end

    assign pready           = 1'b1;
    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_restored_value = r_out;

endmodule

`default_nettype wire

### rtl/mcbf_arith.sv
// Shared arithmetic unit: rounded, saturating Q16.16 multiply in 32x32 partial
// products and a bit-serial rounded Q16.16 divide. Depends on mcbf_pkg.
`default_nettype none

module mcbf_arith (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mcbf_pkg::t_arith_cmd    i_cmd,
    input  logic signed [63:0]      i_opa,
    input  logic signed [63:0]      i_opb,
    output logic                    o_done,
    output logic signed [63:0]      o_result
);
    import mcbf_pkg::*;

    localparam logic [5:0]  DIV_LAST = 6'd62;
    localparam logic [63:0] SAT_MAG  = 64'd1 << 62;
    localparam logic [63:0] DIV_CLIP = 64'd1 << 46;

    typedef enum logic [2:0] {
        U_IDLE,
        U_MUL,
        U_MFIN,
        U_DIV,
        U_DFIN
    } t_ustate;

    t_ustate             r_state;
    logic                r_done;
    logic signed [63:0]  r_result;
    logic [63:0]         r_ma;
    logic [63:0]         r_mb;
    logic                r_neg;
    logic [127:0]        r_acc;
    logic [63:0]         r_pp;
    logic [5:0]          r_cnt;
    logic [62:0]         r_num;
    logic [30:0]         r_rem;
    logic [30:0]         r_dvs;

    logic [63:0]  pp_next;
    logic [127:0] pp_shift;
    logic [1:0]   pp_prev;
    logic [31:0]  rem_sh;
    logic         rem_fit;
    logic [48:0]  mul_rnd;
    logic [63:0]  mul_mag;
    logic [63:0]  div_mn;
    logic [63:0]  div_num;

    always_comb begin
        unique case (r_cnt[1:0])
            2'd0:    pp_next = r_ma[31:0] * r_mb[31:0];
            2'd1:    pp_next = r_ma[31:0] * r_mb[63:32];
            2'd2:    pp_next = r_ma[63:32] * r_mb[31:0];
            default: pp_next = r_ma[63:32] * r_mb[63:32];
        endcase
        pp_prev = r_cnt[1:0] - 2'd1;
        unique case (pp_prev)
            2'd0:    pp_shift = {64'd0, r_pp};
            2'd3:    pp_shift = {r_pp, 64'd0};
            default: pp_shift = {32'd0, r_pp, 32'd0};
        endcase
        rem_sh  = {r_rem, r_num[62]};
        rem_fit = rem_sh >= {1'b0, r_dvs};
        mul_rnd = {1'b0, r_acc[63:16]} + {48'd0, r_acc[15]};
        if (r_acc[127:64] != 64'd0) begin
            mul_mag = SAT_MAG;
        end else if (64'(mul_rnd) > SAT_MAG) begin
            mul_mag = SAT_MAG;
        end else begin
            mul_mag = 64'(mul_rnd);
        end
        div_mn = f_mag(i_opa);
        if (div_mn > DIV_CLIP) begin
            div_mn = DIV_CLIP;
        end
        div_num = (div_mn << 16) + 64'(i_opb[30:1]);
    end

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        unique case (r_state)
            U_IDLE: begin
                if (i_cmd.start) begin
                    r_cnt <= '0;
                    r_neg <= i_opa[63] ^ (i_opb[63] && i_cmd.op == OP_MUL);
                    if (i_cmd.op == OP_MUL) begin
                        r_ma    <= f_mag(i_opa);
                        r_mb    <= f_mag(i_opb);
                        r_acc   <= '0;
                        r_state <= U_MUL;
                    end else begin
                        r_num   <= div_num[62:0];
                        r_rem   <= '0;
                        r_dvs   <= i_opb[30:0];
                        r_state <= U_DIV;
                    end
                end
            end
            U_MUL: begin
                if (r_cnt != 6'd4) begin
                    r_pp <= pp_next;
                end
                if (r_cnt != 6'd0) begin
                    r_acc <= r_acc + pp_shift;
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd4) begin
                    r_state <= U_MFIN;
                end
            end
            U_MFIN: begin
                r_result <= r_neg ? -$signed(mul_mag) : $signed(mul_mag);
                r_done   <= 1'b1;
                r_state  <= U_IDLE;
            end
            U_DIV: begin
                r_rem <= rem_fit ? 31'(rem_sh - {1'b0, r_dvs}) : rem_sh[30:0];
                r_num <= {r_num[61:0], rem_fit};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == DIV_LAST) begin
                    r_state <= U_DFIN;
                end
            end
            U_DFIN: begin
                r_result <= r_neg ? -$signed({1'b0, r_num}) : $signed({1'b0, r_num});
                r_done   <= 1'b1;
                r_state  <= U_IDLE;
            end
            default: r_state <= U_IDLE;
        endcase
        if (!i_rst_n) begin
            r_state <= U_IDLE;
            r_done  <= 1'b0;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

### tb/sv/mem_coefficient_bisection_filter_unit_tb.sv
// Self-checking testbench of the bisection coefficient filter: random and directed beats,
// an in-bench Q16.16 predictor with its own gradient tables, and APB register phases.
// Depends on mcbf_pkg and mem_coefficient_bisection_filter_unit.
`timescale 1ns / 100ps
`default_nettype none

module mem_coefficient_bisection_filter_unit_tb;
    import mcbf_pkg::*;

    localparam int DEPTH = 1024;
    localparam int FRAC = 7;
    localparam int TMAX = 8;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int HOLD_CYCLES = 3000;
    localparam longint unsigned SAT_MAG = 64'd1 << 62;

    typedef struct {
        logic               mode;
        logic signed [31:0] d;
        logic signed [31:0] alpha;
        logic [30:0]        ssig;
        logic [30:0]        nsig;
        logic signed [31:0] m;
    } coef_beat_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic               i_mode = 1'b0;
    logic signed [31:0] i_data_value = '0;
    logic signed [31:0] i_alpha = '0;
    logic [30:0]        i_signal_sigma = '0;
    logic [30:0]        i_noise_sigma = '0;
    logic signed [31:0] i_model_value = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [31:0] o_restored_value;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    mem_coefficient_bisection_filter_unit i_dut (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_mode, .i_data_value, .i_alpha,
        .i_signal_sigma, .i_noise_sigma, .i_model_value, .o_valid, .i_stall,
        .o_restored_value, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always #2 i_clk = ~i_clk;

    logic [31:0] hs_rom [DEPTH];
    logic [31:0] hn_rom [DEPTH];
    logic [6:0]  iter_limit = ITER_LIMIT_RST;
    logic [16:0] conv_thr = CONV_THR_RST;

    coef_beat_t         beat_q[$];
    logic signed [31:0] restored_q[$];
    int  err_cnt = 0;
    int  idle_cnt = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  pressure_on = 1'b0;
    int  hold_cnt = 0;
    bit  in_taken = 1'b0;

    function automatic longint unsigned rm30(longint unsigned a, longint unsigned b);
        return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    function automatic void build_gradient_roms();
        longint unsigned e, q, term, q2, g, a, fsum, f0, f, t, corr, ev, cg, xq, xe, xc;
        e = 64'd1 << (29 - 2 * FRAC);
        q = ONE30;
        term = ONE30;
        g = ONE30;
        fsum = 0;
        f0 = 0;
        for (int k = 1; k <= 6; k++) begin
            term = rm30(term, e) / k;
            if (k % 2 == 1) q = q - term;
            else q = q + term;
        end
        q2 = rm30(q, q);
        a = q;
        for (int i = 0; i < DEPTH; i++) begin
            if (i > 0) begin
                g = rm30(g, a);
                a = rm30(a, q2);
            end
            f = rm30(C1_Q30, g);
            fsum += f;
            if (i == 0) f0 = f;
            t = (2 * fsum - f0 - f + (64'd1 << FRAC)) >> (FRAC + 1);
            if (i == 0) t = 0;
            corr = (f * i / 12 + (64'd1 << (3 * FRAC - 1))) >> (3 * FRAC);
            ev = t + corr;
            if (ev > ONE30) ev = ONE30;
            cg = (f < C1_Q30) ? ((C1_Q30 - f + (64'd1 << 13)) >> 14) : 0;
            xq = longint'(i) << (16 - FRAC);
            xe = (xq * ev + (64'd1 << 29)) >> 30;
            xc = (xq * (ONE30 - ev) + (64'd1 << 29)) >> 30;
            hs_rom[i] = 32'(cg - xe);
            hn_rom[i] = 32'(cg + xc);
        end
    endfunction

    function automatic longint mul_q16(longint a, longint b);
        longint unsigned ma, mb, p, r;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        if (ma != 0 && mb > 64'hFFFF_FFFF_FFFF_FFFF / ma) begin
            r = SAT_MAG;
        end else begin
            p = ma * mb;
            r = (p >> 16) + ((p >> 15) & 1);
            if (r > SAT_MAG) r = SAT_MAG;
        end
        return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint div_q16(longint n, longint unsigned dv);
        longint unsigned mn, r;
        mn = (n < 0) ? -n : n;
        if (mn > (64'd1 << 46)) mn = 64'd1 << 46;
        r = ((mn << 16) + dv / 2) / dv;
        return (n < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic int rom_index(longint v);
        longint unsigned idx;
        idx = (longint'(v) + (64'd1 << (15 - FRAC))) >> (16 - FRAC);
        if (idx > DEPTH - 1) idx = DEPTH - 1;
        return int'(idx);
    endfunction

    function automatic longint hs_grad(longint v);
        if (v >= (longint'(TMAX) << 16)) return longint'($signed(hs_rom[DEPTH - 1])) - v;
        if (v > 0) return longint'($signed(hs_rom[rom_index(v)]));
        return 0;
    endfunction

    function automatic longint hn_grad(longint v);
        if (v >= (longint'(TMAX) << 16)) return longint'($signed(hn_rom[DEPTH - 1]));
        if (v > 0) return longint'($signed(hn_rom[rom_index(v)]));
        return 0;
    endfunction

    function automatic logic signed [31:0] restore_coef(coef_beat_t b);
        longint d, al, m, sg, sn, res, lo, hi, c, diff, w, dm, valdat, thr;
        int lim, iter;
        d = b.d;
        al = b.alpha;
        m = b.m;
        sg = (b.ssig == 0) ? 1 : longint'(b.ssig);
        sn = (b.nsig == 0) ? 1 : longint'(b.nsig);
        lim = (iter_limit == 0) ? 1 : int'(iter_limit);
        thr = longint'(conv_thr);
        lo = 0;
        c = 0;
        iter = 0;
        if (al == 0) begin
            res = d;
        end else if (al < 0) begin
            res = m;
        end else begin
            dm = (d >= m) ? d - m : m - d;
            if (!b.mode) begin
                valdat = div_q16(dm, sg);
                hi = valdat + (longint'(3) << 16);
            end else begin
                valdat = dm;
                hi = valdat + 3 * ((sg > sn) ? sg : sn);
            end
            forever begin
                iter++;
                c = (lo + hi) >>> 1;
                if (!b.mode)
                    diff = hs_grad(valdat - c) + mul_q16(al, hn_grad(c));
                else
                    diff = mul_q16(sg, hs_grad(div_q16(valdat - c, sg)))
                         + mul_q16(mul_q16(al, sn), hn_grad(div_q16(c, sn)));
                if (diff > 0) hi = c;
                else lo = c;
                w = b.mode ? div_q16(hi - lo, sg) : hi - lo;
                if (!(w > thr && iter < lim)) break;
            end
            if (!b.mode) c = mul_q16(c, sg);
            res = ((d >= m) ? c : -c) + m;
        end
        if (res > 64'sd2147483647) res = 64'sd2147483647;
        if (res < -64'sd2147483648) res = -64'sd2147483648;
        return 32'(res);
    endfunction

    task automatic report_mismatch(logic signed [31:0] want, logic signed [31:0] got);
        $display("restored_value mismatch: expected %0d got %0d", want, got);
        err_cnt++;
    endtask

    // driver: load the next beat once the current one is taken
    always @(negedge i_clk) begin
        coef_beat_t b;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (beat_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                b = beat_q.pop_front();
                i_valid <= 1'b1;
                i_mode <= b.mode;
                i_data_value <= b.d;
                i_alpha <= b.alpha;
                i_signal_sigma <= b.ssig;
                i_noise_sigma <= b.nsig;
                i_model_value <= b.m;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (pressure_on && hold_cnt < HOLD_CYCLES) begin
            i_stall <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // monitor: predict on input beats, check output beats, watch for hangs
    always @(posedge i_clk) begin
        coef_beat_t b;
        logic signed [31:0] want;
        in_taken <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) begin
            b.mode = i_mode;
            b.d = i_data_value;
            b.alpha = i_alpha;
            b.ssig = i_signal_sigma;
            b.nsig = i_noise_sigma;
            b.m = i_model_value;
            restored_q.push_back(restore_coef(b));
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (restored_q.size() == 0) begin
                $display("restored_value beat with nothing expected: %0d", o_restored_value);
                err_cnt++;
            end else begin
                want = restored_q.pop_front();
                if (want !== o_restored_value) report_mismatch(want, o_restored_value);
            end
        end
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic apb_write(logic addr_sel, logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {addr_sel, 2'b00};
        pwdata <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (beat_q.size() > 0 || i_valid || restored_q.size() > 0);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(65536 * 12)) - 32'sd393216;
            default: return $signed($urandom_range(65536 * 4)) - 32'sd131072;
        endcase
    endfunction

    function automatic logic [30:0] pick_sigma();
        case ($urandom_range(9))
            0: return 31'($urandom);
            1: return 31'd0;
            2: return 31'($urandom_range(16));
            default: return 31'($urandom_range(3 << 16, 1 << 12));
        endcase
    endfunction

    function automatic coef_beat_t random_beat(int mode1_pct);
        coef_beat_t b;
        b.mode = ($urandom_range(99) < mode1_pct);
        b.d = pick_value();
        b.m = ($urandom_range(3) == 0) ? pick_value() : 32'sd0;
        case ($urandom_range(9))
            0: b.alpha = 32'sd0;
            1: b.alpha = -$signed({1'b0, 31'($urandom)});
            2: b.alpha = $urandom;
            default: b.alpha = $signed($urandom_range(8 << 16, 1));
        endcase
        b.ssig = pick_sigma();
        b.nsig = pick_sigma();
        return b;
    endfunction

    task automatic run_phase(logic [31:0] lim, logic [31:0] thr, int n, int sidle,
                             int rstall, bit hold);
        apb_write(REG_ITER_LIMIT, lim);
        apb_write(REG_CONV_THR, thr);
        @(posedge i_clk);
        iter_limit <= lim[6:0];
        conv_thr <= thr[16:0];
        send_idle_pct <= sidle;
        recv_stall_pct <= rstall;
        pressure_on <= hold;
        for (int k = 0; k < n; k++) beat_q.push_back(random_beat((lim > 40) ? 8 : 25));
        drain();
    endtask

    function automatic coef_beat_t mk(logic mode, logic signed [31:0] d, logic signed [31:0] al,
                                      logic [30:0] s, logic [30:0] ns, logic signed [31:0] m);
        coef_beat_t b;
        b.mode = mode;
        b.d = d;
        b.alpha = al;
        b.ssig = s;
        b.nsig = ns;
        b.m = m;
        return b;
    endfunction

    initial begin
        build_gradient_roms();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        beat_q.push_back(mk(0, 32'sh7FFFFFFF, 0, 65536, 65536, 0));
        beat_q.push_back(mk(1, 32'sh80000000, 0, 0, 0, 32'sh7FFFFFFF));
        beat_q.push_back(mk(0, 12345, 32'sh80000000, 65536, 0, 32'sh80000000));
        beat_q.push_back(mk(1, 12345, -1, 65536, 0, 32'sh7FFFFFFF));
        beat_q.push_back(mk(0, 65536, 1, 65536, 65536, 0));
        beat_q.push_back(mk(0, 3 << 16, 65536, 65536, 65536, 0));
        beat_q.push_back(mk(0, -(3 << 16), 65536, 0, 0, 65536));
        beat_q.push_back(mk(0, 20 << 16, 32768, 65536, 0, 0));
        beat_q.push_back(mk(0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0, 32'sh7FFFFFFF));
        beat_q.push_back(mk(0, 32'sh80000000, 65536, 1, 1, 32'sh80000000));
        beat_q.push_back(mk(0, 100, 65536, 31'h7FFFFFFF, 0, 100));
        beat_q.push_back(mk(0, 32'sh80000000, 65536, 65536, 0, 32'sh7FFFFFFF));
        beat_q.push_back(mk(1, 2 << 16, 65536, 65536, 65536, 0));
        beat_q.push_back(mk(1, -(5 << 16), 131072, 32768, 0, 65536));
        beat_q.push_back(mk(1, 32'sh7FFFFFFF, 65536, 31'h7FFFFFFF, 31'h7FFFFFFF, 0));
        beat_q.push_back(mk(1, 300, 200000, 0, 65536, 0));
        beat_q.push_back(mk(0, 65537, 65536, 2, 0, 1));
        beat_q.push_back(mk(0, 9 << 16, 1 << 20, 65536, 0, 0));
        drain();
        run_phase(16, 7, 200, 0, 0, 0);
        run_phase(8, 100, 200, 65, 0, 0);
        run_phase(24, 1, 150, 0, 65, 1);
        run_phase(4, 65536, 150, 10, 10, 0);
        run_phase(127, 0, 12, 0, 0, 0);
        run_phase(0, 131071, 40, 65, 65, 0);
        repeat (50) @(posedge i_clk);
        if (err_cnt == 0 && restored_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
rtl/mcbf_pkg.sv
rtl/mcbf_arith.sv
rtl/mem_coefficient_bisection_filter_unit.sv
tb/sv/mem_coefficient_bisection_filter_unit_tb.sv
